// ===== hw/rtl/sfpd_pkg.sv =====
package sfpd_pkg;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [7:0]  FILL_BYTE  = 8'hFF;
   localparam logic [15:0] FILL_CRC   = 16'hFFFF;
   localparam logic [8:0]  HDR_BYTES  = 9'd12;

   // packet byte offsets of the header fields
   localparam logic [7:0] OFS_CRC_LO = 8'd0;
   localparam logic [7:0] OFS_CRC_HI = 8'd1;
   localparam logic [7:0] OFS_LENGTH = 8'd2;
   localparam logic [7:0] OFS_FLAGS  = 8'd3;

   typedef enum logic [1:0] {
      STATUS_CRC_GOOD = 2'd0,
      STATUS_CRC_BAD  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // one byte handed to the parser
   typedef struct packed {
      logic       step;
      logic [7:0] rx_byte;
      logic       transfer_start;
   } step_type;

   // packet descriptor from the parser
   typedef struct packed {
      logic       valid;
      status_type status;
      logic [7:0] packet_offset;
      logic [8:0] packet_size;
   } desc_type;

   // crc-16-ccitt, polynomial 0x1021, one byte
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] x;
      x = crc[15:8] ^ b;
      x = x ^ {4'h0, x[7:4]};
      return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
   endfunction

endpackage

// ===== hw/rtl/sfpd_parser.sv =====
module sfpd_parser #(
   parameter int TRANSFER_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  sfpd_pkg::step_type req,
   output sfpd_pkg::desc_type res
);
   import sfpd_pkg::*;

   localparam logic [9:0] XFER_END = 10'(TRANSFER_BYTES);

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  begin_ff, begin_in;
   logic [8:0]  len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] stored_ff, stored_in;
   logic        bogus_ff, bogus_in;
   logic        stopped_ff, stopped_in;

   logic        was_stopped;
   logic [7:0]  rel;
   logic [9:0]  rounded;
   logic [9:0]  next_begin;
   logic [9:0]  pkt_end;

   always_comb begin
      pos_in     = pos_ff;
      begin_in   = begin_ff;
      len_in     = len_ff;
      crc_in     = crc_ff;
      stored_in  = stored_ff;
      bogus_in   = bogus_ff;
      stopped_in = stopped_ff;
      if (req.transfer_start) begin
         pos_in     = '0;
         begin_in   = '0;
         len_in     = '0;
         crc_in     = CRC_INIT;
         stored_in  = '0;
         bogus_in   = 1'b0;
         stopped_in = 1'b0;
      end
      res.valid         = 1'b0;
      res.status        = STATUS_CRC_GOOD;
      res.packet_offset = begin_in;
      res.packet_size   = len_in;
      was_stopped       = stopped_in;
      rel               = pos_in - begin_in;
      rounded           = '0;
      next_begin        = '0;
      pkt_end           = '0;

      if (!was_stopped) begin
         if (pos_in >= begin_in) begin
            if (rel == OFS_CRC_LO) begin
               stored_in = {8'h00, req.rx_byte};
            end else if (rel == OFS_CRC_HI) begin
               stored_in = {req.rx_byte, stored_in[7:0]};
               bogus_in  = (stored_in == FILL_CRC);
            end else if (rel == OFS_LENGTH) begin
               if (req.rx_byte == 8'h00) begin
                  stopped_in = 1'b1;
               end else begin
                  len_in  = {1'b0, req.rx_byte} + HDR_BYTES;
                  pkt_end = {2'b00, begin_in} + {1'b0, len_in};
                  if (pkt_end > XFER_END) begin
                     res.valid         = 1'b1;
                     res.status        = STATUS_OVERFLOW;
                     res.packet_offset = begin_in;
                     res.packet_size   = len_in;
                     stopped_in        = 1'b1;
                  end
               end
            end else if (rel == OFS_FLAGS) begin
               bogus_in = bogus_in && (req.rx_byte == FILL_BYTE);
            end

            if (!stopped_in && rel >= OFS_LENGTH && {1'b0, rel} < len_in) begin
               crc_in = crc_update(crc_in, req.rx_byte);
               if ({1'b0, rel} == len_in - 9'd1) begin
                  if (!bogus_in) begin
                     res.valid         = 1'b1;
                     res.status        = (crc_in == stored_in) ? STATUS_CRC_GOOD
                                                               : STATUS_CRC_BAD;
                     res.packet_offset = begin_in;
                     res.packet_size   = len_in;
                  end
                  // pad to a 4-byte boundary
                  rounded    = {1'b0, len_in} + 10'd3;
                  next_begin = {2'b00, begin_in} + {rounded[9:2], 2'b00};
                  if (next_begin >= XFER_END) begin
                     stopped_in = 1'b1;
                  end else begin
                     begin_in = next_begin[7:0];
                  end
                  crc_in   = CRC_INIT;
                  bogus_in = 1'b0;
               end
            end
         end
         if ({2'b00, pos_in} + 10'd1 >= XFER_END) begin
            stopped_in = 1'b1;
         end
         pos_in = pos_in + 8'd1;
      end
      res.valid = res.valid && req.step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         begin_ff   <= '0;
         len_ff     <= '0;
         crc_ff     <= CRC_INIT;
         stored_ff  <= '0;
         bogus_ff   <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (req.step) begin
         pos_ff     <= pos_in;
         begin_ff   <= begin_in;
         len_ff     <= len_in;
         crc_ff     <= crc_in;
         stored_ff  <= stored_in;
         bogus_ff   <= bogus_in;
         stopped_ff <= stopped_in;
      end
   end

   // packets always start on a 4-byte boundary
   a_begin_aligned : assert property (@(posedge clock) disable iff (reset)
      begin_ff[1:0] == 2'b00)
      else $error("packet start not word aligned");

   // an overflow descriptor stops parsing for the rest of the transfer
   a_overflow_stops : assert property (@(posedge clock) disable iff (reset)
      res.valid && res.status == STATUS_OVERFLOW |=> stopped_ff)
      else $error("parsing continued after overflow");

   // a descriptor always covers a non-empty payload
   a_size_min : assert property (@(posedge clock) disable iff (reset)
      res.valid |-> res.packet_size > HDR_BYTES)
      else $error("descriptor with empty payload");

   // a stopped parser produces nothing until a new transfer starts
   a_stopped_quiet : assert property (@(posedge clock) disable iff (reset)
      stopped_ff && !req.transfer_start |-> !res.valid)
      else $error("descriptor while parsing stopped");

endmodule

// ===== hw/rtl/spi_frame_packet_deframer.sv =====
// channel  | dir | tdata (low bit up)                      | tuser
// ---------+-----+-----------------------------------------+-----------------------
// req_     | in  | [7:0] rx_byte                           | [0] transfer_start
// rsp_     | out | [7:0] packet_offset, [16:8] packet_size,| [1:0] status
//          |     | [23:17] zero                            |
//
// one request per cycle while no held descriptor stalls the input register; an accepted
// byte waits in the input register, crc and header parsing run in the cycle in which it
// advances, and the descriptor is written to the result register at the end of that cycle
// reset (synchronous, active high) clears the parser state as at the start of a transfer
// a held descriptor stalls the input register until it is taken, whether or not the
// next byte produces a descriptor
module spi_frame_packet_deframer #(
   parameter int TRANSFER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] transfer_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] packet_offset, [16:8] packet_size, [23:17] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import sfpd_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic [7:0] rsp_offset_ff;
   logic [8:0] rsp_size_ff;

   logic       advance;
   logic       req_take;
   step_type   step;
   desc_type   desc;

   // the held byte moves on once the result register is free or being emptied
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign step.step           = advance;
   assign step.rx_byte        = in_byte_ff;
   assign step.transfer_start = in_start_ff;

   sfpd_parser #(
      .TRANSFER_BYTES(TRANSFER_BYTES)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .req  (step),
      .res  (desc)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = desc.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser[0];
      end
      if (advance && desc.valid) begin
         rsp_status_ff <= desc.status;
         rsp_offset_ff <= desc.packet_offset;
         rsp_size_ff   <= desc.packet_size;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_size_ff, rsp_offset_ff};
   assign rsp_tuser  = rsp_status_ff;

   // a waiting request byte is never dropped
   a_in_held : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("request byte lost in input register");

   // an untaken descriptor is never overwritten
   a_rsp_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("descriptor overwritten while stalled");

   // a descriptor from the parser always lands in the result register
   a_desc_lands : assert property (@(posedge clock) disable iff (reset)
      advance && desc.valid |=> rsp_valid_ff)
      else $error("descriptor dropped");

endmodule
